// File: hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ymr_pkg.sv
// ----------------------------------------------------------------------------
// ymr_pkg
// Shared constants, types and the crc step for the ymodem receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package ymr_pkg;

    localparam int PACKET_BYTES_DEF = 1024;
    localparam int SHORT_BYTES      = 128;

    // protocol header bytes and size field characters
    localparam logic [7:0] BYTE_SOH = 8'h01;
    localparam logic [7:0] BYTE_STX = 8'h02;
    localparam logic [7:0] BYTE_EOT = 8'h04;
    localparam logic [7:0] BYTE_CAN = 8'h18;
    localparam logic [7:0] BYTE_NUL = 8'h00;
    localparam logic [7:0] BYTE_D0  = 8'h30;
    localparam logic [7:0] BYTE_D9  = 8'h39;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef logic [2:0] t_reply;
    localparam t_reply REPLY_NONE = 3'd0;
    localparam t_reply REPLY_C    = 3'd1;
    localparam t_reply REPLY_ACK  = 3'd2;
    localparam t_reply REPLY_NAK  = 3'd3;
    localparam t_reply REPLY_CAN  = 3'd4;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_WAIT     = 2'd0;
    localparam t_phase PH_RECV     = 2'd1;
    localparam t_phase PH_COMPLETE = 2'd2;
    localparam t_phase PH_CANCEL   = 2'd3;

    // size field parser progress
    typedef logic [1:0] t_name;
    localparam t_name NM_NAME   = 2'd0;
    localparam t_name NM_DIGITS = 2'd1;
    localparam t_name NM_DONE   = 2'd2;

    // one byte of xmodem crc-16, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    // largest value that may still take digit d without passing 2^32-1
    function automatic logic [31:0] digit_limit(input logic [3:0] d);
        return (d <= 4'd5) ? 32'd429496729 : 32'd429496728;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ymodem_receiver_top.sv
// ----------------------------------------------------------------------------
// ymodem_receiver_top
// YModem upload receiver with crc-16, packet store and flash write requests.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one transaction per serial
// byte (i_kind = 0) or per packet store fetch (i_kind = 1). Every input
// transaction yields exactly one output transaction (o_out_valid /
// i_out_stall) with the reply code, erase and write requests, fetch data and
// status.
// The result is registered: the result register loads at the accepting edge,
// and fetch data comes from the store's registered read port in the same cycle.
// Throughput is one transaction per cycle while the output is not stalled; crc,
// header checks and the size parse run one byte per cycle, and the store takes one write or one read.
// While the output is stalled the held result stays put and the input
// channel stalls too. Reset (synchronous, active low) returns to waiting for
// the first byte, clears flash_base, and leaves the store contents undefined;
// no clearing pass is needed.
// flash_base is written through i_cfg_we / i_cfg_wdata; the user writes it only while idle, unchecked by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module ymodem_receiver_top #(
    parameter int PACKET_BYTES = ymr_pkg::PACKET_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_kind,
    input  wire  [7:0]  i_rx_byte,
    input  wire  [9:0]  i_fetch_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [2:0]  o_reply_code,
    output logic        o_erase_request,
    output logic        o_write_valid,
    output logic [31:0] o_write_address,
    output logic [10:0] o_write_length,
    output logic [7:0]  o_fetch_data,
    output logic [31:0] o_upload_size,
    output logic [1:0]  o_phase,
    output logic        o_size_match
);
    import ymr_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);
    localparam logic [10:0] LEN_LONG  = 11'(PACKET_BYTES);
    localparam logic [10:0] LEN_SHORT = 11'(SHORT_BYTES);

    // control registers
    logic [31:0] r_flash_base;
    t_phase      r_phase, n_phase;
    logic [10:0] r_byte_count, n_byte_count;
    logic        r_pkt_kind, n_pkt_kind;
    logic [7:0]  r_exp_seq, n_exp_seq;
    logic [7:0]  r_seq_byte, n_seq_byte;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_high, n_crc_high;
    logic [31:0] r_rcv_count, n_rcv_count;
    logic [31:0] r_size, n_size;
    logic        r_first, n_first;
    logic        r_cancel, n_cancel;
    t_name       r_name, n_name;
    logic [31:0] r_parse_val, n_parse_val;

    // result register
    logic        r_out_valid;
    t_reply      r_reply, n_reply;
    logic        r_erase, n_erase;
    logic        r_wvalid, n_wvalid;
    logic [31:0] r_waddr, n_waddr;
    logic [10:0] r_wlen, n_wlen;
    logic        r_is_fetch;
    logic        r_fetch_ok;
    logic [31:0] r_fsize;
    t_phase      r_ophase;
    logic        r_match;

    // packet store
    logic [7:0]  r_store [PACKET_BYTES];
    logic [7:0]  r_rd_data;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;

    logic        accept;
    logic        serial;
    logic [10:0] pkt_len;
    logic [3:0]  digit;
    logic        is_digit;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign serial     = accept && !i_kind;
    assign pkt_len    = r_pkt_kind ? LEN_LONG : LEN_SHORT;
    assign digit      = 4'(i_rx_byte - BYTE_D0);
    assign is_digit   = (i_rx_byte >= BYTE_D0) && (i_rx_byte <= BYTE_D9);
    assign mem_waddr  = AW'(r_byte_count - 11'd3);

    // protocol next state for one serial byte
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_pkt_kind   = r_pkt_kind;
        n_exp_seq    = r_exp_seq;
        n_seq_byte   = r_seq_byte;
        n_crc        = r_crc;
        n_crc_high   = r_crc_high;
        n_rcv_count  = r_rcv_count;
        n_size       = r_size;
        n_first      = r_first;
        n_cancel     = r_cancel;
        n_name       = r_name;
        n_parse_val  = r_parse_val;
        n_reply      = REPLY_NONE;
        n_erase      = 1'b0;
        n_wvalid     = 1'b0;
        n_waddr      = 32'd0;
        n_wlen       = 11'd0;
        mem_we       = 1'b0;
        if (serial) begin
            if (r_phase == PH_WAIT) begin
                n_reply      = REPLY_C;
                n_phase      = PH_RECV;
                n_byte_count = 11'd0;
                n_exp_seq    = 8'd0;
                n_first      = 1'b1;
                n_cancel     = 1'b0;
                n_name       = NM_NAME;
            end else if (r_phase == PH_RECV) begin
                if (r_byte_count == 11'd0) begin
                    // header byte
                    if (i_rx_byte == BYTE_CAN) begin
                        if (r_cancel) begin
                            n_phase = PH_CANCEL;
                        end else begin
                            n_cancel = 1'b1;
                        end
                    end else begin
                        n_cancel = 1'b0;
                        if (i_rx_byte == BYTE_SOH || i_rx_byte == BYTE_STX) begin
                            n_pkt_kind   = (i_rx_byte == BYTE_STX);
                            n_crc        = 16'd0;
                            n_byte_count = 11'd1;
                            n_name       = NM_NAME;
                            n_parse_val  = 32'd0;
                        end else if (i_rx_byte == BYTE_EOT) begin
                            n_reply = REPLY_ACK;
                            n_phase = PH_COMPLETE;
                        end else begin
                            n_reply = REPLY_NAK;
                        end
                    end
                end else if (r_byte_count == 11'd1) begin
                    n_seq_byte   = i_rx_byte;
                    n_byte_count = 11'd2;
                end else if (r_byte_count == 11'd2) begin
                    if (r_seq_byte != r_exp_seq || i_rx_byte != ~r_seq_byte) begin
                        n_reply      = REPLY_NAK;
                        n_byte_count = 11'd0;
                    end else begin
                        n_byte_count = 11'd3;
                    end
                end else if (r_byte_count < pkt_len + 11'd3) begin
                    // data byte: store, crc and size field parse
                    mem_we       = 1'b1;
                    n_crc        = crc_step(r_crc, i_rx_byte);
                    n_byte_count = r_byte_count + 11'd1;
                    case (r_name)
                        NM_NAME: begin
                            if (i_rx_byte == BYTE_NUL) n_name = NM_DIGITS;
                        end
                        NM_DIGITS: begin
                            if (!is_digit) begin
                                n_name = NM_DONE;
                            end else if (r_parse_val > digit_limit(digit)) begin
                                n_parse_val = 32'hFFFF_FFFF;
                            end else begin
                                n_parse_val = {r_parse_val[28:0], 3'b000}
                                            + {r_parse_val[30:0], 1'b0}
                                            + {28'd0, digit};
                            end
                        end
                        default: ;
                    endcase
                end else if (r_byte_count == pkt_len + 11'd3) begin
                    n_crc_high   = i_rx_byte;
                    n_byte_count = r_byte_count + 11'd1;
                end else begin
                    // crc low byte closes the packet
                    n_byte_count = 11'd0;
                    if (r_crc != {r_crc_high, i_rx_byte}) begin
                        n_reply = REPLY_NAK;
                    end else if (r_first) begin
                        if (r_name == NM_NAME) begin
                            n_reply = REPLY_CAN;
                            n_phase = PH_CANCEL;
                        end else begin
                            n_size      = r_parse_val;
                            n_first     = 1'b0;
                            n_rcv_count = 32'd0;
                            n_erase     = 1'b1;
                            n_reply     = REPLY_ACK;
                            n_exp_seq   = r_exp_seq + 8'd1;
                        end
                    end else begin
                        n_wvalid    = 1'b1;
                        n_waddr     = r_flash_base + r_rcv_count;
                        n_wlen      = pkt_len;
                        n_rcv_count = r_rcv_count + {21'd0, pkt_len};
                        n_reply     = REPLY_ACK;
                        n_exp_seq   = r_exp_seq + 8'd1;
                    end
                end
            end
        end
    end

    // state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_base <= 32'd0;
            r_phase      <= PH_WAIT;
            r_byte_count <= 11'd0;
            r_pkt_kind   <= 1'b0;
            r_exp_seq    <= 8'd0;
            r_seq_byte   <= 8'd0;
            r_crc        <= 16'd0;
            r_crc_high   <= 8'd0;
            r_rcv_count  <= 32'd0;
            r_size       <= 32'd0;
            r_first      <= 1'b1;
            r_cancel     <= 1'b0;
            r_name       <= NM_NAME;
            r_parse_val  <= 32'd0;
        end else begin
            if (i_cfg_we) r_flash_base <= i_cfg_wdata;
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_pkt_kind   <= n_pkt_kind;
            r_exp_seq    <= n_exp_seq;
            r_seq_byte   <= n_seq_byte;
            r_crc        <= n_crc;
            r_crc_high   <= n_crc_high;
            r_rcv_count  <= n_rcv_count;
            r_size       <= n_size;
            r_first      <= n_first;
            r_cancel     <= n_cancel;
            r_name       <= n_name;
            r_parse_val  <= n_parse_val;
        end
    end

    // packet store, one write or one read per cycle, none while the input stalls
    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[mem_waddr] <= i_rx_byte;
        if (accept && i_kind) r_rd_data <= r_store[i_fetch_index[AW-1:0]];
    end

    // output transaction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_reply    <= n_reply;
            r_erase    <= n_erase;
            r_wvalid   <= n_wvalid;
            r_waddr    <= n_waddr;
            r_wlen     <= n_wlen;
            r_is_fetch <= i_kind;
            r_fetch_ok <= ({1'b0, i_fetch_index} < 11'(PACKET_BYTES));
            r_fsize    <= n_size;
            r_ophase   <= n_phase;
            r_match    <= (n_phase == PH_COMPLETE) && (n_rcv_count == n_size);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reply_code    = r_reply;
    assign o_erase_request = r_erase;
    assign o_write_valid   = r_wvalid;
    assign o_write_address = r_waddr;
    assign o_write_length  = r_wlen;
    assign o_fetch_data    = (r_is_fetch && r_fetch_ok) ? r_rd_data : 8'd0;
    assign o_upload_size   = r_fsize;
    assign o_phase         = r_ophase;
    assign o_size_match    = r_match;

endmodule

`default_nettype wire

// File: hw/rtl/ymr_checker.sv
// ----------------------------------------------------------------------------
// ymr_checker
// Port level checks for the ymodem receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ymr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [2:0]  o_reply_code,
    input wire        o_erase_request,
    input wire        o_write_valid,
    input wire [10:0] o_write_length,
    input wire [1:0]  o_phase,
    input wire        o_size_match
);
    import ymr_pkg::*;

    // reply code stays within the defined set
    `ASSERT_IMPLY(a_reply_range, i_clk, i_rst_n, o_out_valid, o_reply_code <= REPLY_CAN)
    // size match only reported once the transfer is complete
    `ASSERT_IMPLY(a_match_phase, i_clk, i_rst_n, o_out_valid && o_size_match, o_phase == PH_COMPLETE)
    // erase and write never come from the same packet, and either one is acked
    `ASSERT_IMPLY(a_write_ack, i_clk, i_rst_n, o_out_valid && (o_write_valid || o_erase_request), !(o_write_valid && o_erase_request) && o_reply_code == REPLY_ACK)
    // a stalled result holds
    `ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_reply_code) && $stable(o_write_length))

endmodule

bind ymodem_receiver_top ymr_checker u_ymr_checker (.*);

`default_nettype wire
